// ----- sv/pow2_class_allocator_unit_defines.svh -----
// Assertion macros for the power-of-two class allocator.
// Used by the checker; depends on clk and arst_n being visible where expanded.
`ifndef POW2_CLASS_ALLOCATOR_UNIT_DEFINES_SVH
`define POW2_CLASS_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PCA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PCA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/pca_pkg.sv -----
// Shared types, codes, default parameters and helper functions of the allocator.
// No dependencies; every other file of the block except the defines header imports this package.
`timescale 1ns / 1ps

package pca_pkg;

	// Default configuration of the arena.
	localparam int PCA_ARENA_BYTES    = 65536;
	localparam int PCA_MIN_CLASS_LOG2 = 4;
	localparam int PCA_MAX_CLASS_LOG2 = 12;
	localparam int PCA_HEADER_BYTES   = 16;

	// Fixed field widths on the stream ports.
	localparam int PCA_SIZE_W   = 16;
	localparam int PCA_ADDR_W   = 16;
	localparam int PCA_STATUS_W = 2;

	// Depth of the queue between classifier and executor.
	localparam int PCA_QUEUE_DEPTH = 2;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} pca_req_t;

	typedef enum logic [PCA_STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NO_ROOM   = 2'd1,
		STATUS_TOO_LARGE = 2'd2
	} pca_status_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_LOAD,
		BK_EXEC
	} pca_state_t;

	function automatic int pca_class_count(int min_l2, int max_l2);
		return (max_l2 >= min_l2) ? (max_l2 - min_l2 + 2) : 1;
	endfunction

	function automatic int pca_cls_w(int min_l2, int max_l2);
		int cc;
		cc = pca_class_count(min_l2, max_l2);
		return (cc > 1) ? $clog2(cc) : 1;
	endfunction

	function automatic int pca_slot_w(int min_l2);
		return PCA_ADDR_W - min_l2;
	endfunction

	// Queue entry: is_free, reject, class, slot (lowest bit first).
	function automatic int pca_entry_w(int min_l2, int max_l2);
		return 2 + pca_cls_w(min_l2, max_l2) + pca_slot_w(min_l2);
	endfunction

	// Position of the highest set bit; 0 for an input of 0 or 1.
	function automatic logic [4:0] pca_floor_log2(logic [PCA_SIZE_W:0] v);
		logic [4:0] r;
		r = '0;
		for (int i = 1; i <= PCA_SIZE_W; i++) begin
			if (v[i]) begin
				r = 5'(i);
			end
		end
		return r;
	endfunction

endpackage

// ----- sv/pow2_class_allocator_unit.sv -----
// Power-of-two segregated-fit allocator for a single arena. Each request is one
// transfer on the slave stream: tuser carries the request kind (allocate or free),
// tdata the payload size and the data offset to free. Every request gives exactly
// one result transfer on the master stream: a status in tuser and, for a
// successful allocation, the data offset past the chunk header in tdata. An
// allocation is rounded up to a chunk of 2^(floor(log2(size + header)) + 1) bytes,
// at least 2^MIN_CLASS_LOG2, and is served from that class's free list or else by
// bumping the arena pointer. A free either rolls the bump pointer back, when the
// chunk ends at it, or pushes the chunk on its class list; null, misaligned,
// out-of-arena and double frees are ignored. Requests are classified on entry and
// wait in a two-entry queue; the executor reads the link or slot memory in BK_LOAD,
// then writes back and loads the result register in BK_EXEC, and takes a new
// request only once it is through with the last one; BK_EXEC waits while an
// earlier result is still held on the master stream. After reset the slot memory
// is swept clear, all 2^(16 - MIN_CLASS_LOG2) entries (4096 with the defaults),
// and s_axis_tready stays low until the sweep is done.
`timescale 1ns / 1ps

module pow2_class_allocator_unit import pca_pkg::*; #(
	parameter int ARENA_BYTES    = PCA_ARENA_BYTES,
	parameter int MIN_CLASS_LOG2 = PCA_MIN_CLASS_LOG2,
	parameter int MAX_CLASS_LOG2 = PCA_MAX_CLASS_LOG2,
	parameter int HEADER_BYTES   = PCA_HEADER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] request_size, [31:16] free_address
	input  logic [0:0]  s_axis_tuser,  // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [15:0] data_address
	output logic [1:0]  m_axis_tuser   // [1:0] status
);

	localparam int ENTRY_W = pca_entry_w(MIN_CLASS_LOG2, MAX_CLASS_LOG2);

	logic               push;
	logic               q_full;
	logic               q_empty;
	logic               q_pop;
	logic               clear_busy;
	logic [ENTRY_W-1:0] push_entry;
	logic [ENTRY_W-1:0] pop_entry;
	pca_status_t        res_status;

	// Front end: handshake on the slave side and request classification.
	pca_front #(
		.ARENA_BYTES   (ARENA_BYTES),
		.MIN_CLASS_LOG2(MIN_CLASS_LOG2),
		.MAX_CLASS_LOG2(MAX_CLASS_LOG2),
		.HEADER_BYTES  (HEADER_BYTES)
	) u_front (
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_type   (pca_req_t'(s_axis_tuser[0])),
		.in_size   (s_axis_tdata[15:0]),
		.in_addr   (s_axis_tdata[31:16]),
		.q_full    (q_full),
		.clear_busy(clear_busy),
		.push      (push),
		.entry     (push_entry)
	);

	// Queue: lets the front keep taking transfers while the executor is busy.
	pca_queue #(
		.W(ENTRY_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_entry),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (pop_entry),
		.empty    (q_empty)
	);

	// Executor: owns all allocator state and the result register.
	pca_back #(
		.ARENA_BYTES   (ARENA_BYTES),
		.MIN_CLASS_LOG2(MIN_CLASS_LOG2),
		.MAX_CLASS_LOG2(MAX_CLASS_LOG2),
		.HEADER_BYTES  (HEADER_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (pop_entry),
		.q_pop     (q_pop),
		.clear_busy(clear_busy),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_status(res_status),
		.out_addr  (m_axis_tdata)
	);

	assign m_axis_tuser = res_status;

endmodule

// ----- sv/pca_front.sv -----
// Front end of the allocator: accepts requests and classifies them.
// Depends on pca_pkg; feeds pca_queue with packed entries.
`timescale 1ns / 1ps

module pca_front import pca_pkg::*; #(
	parameter int ARENA_BYTES    = PCA_ARENA_BYTES,
	parameter int MIN_CLASS_LOG2 = PCA_MIN_CLASS_LOG2,
	parameter int MAX_CLASS_LOG2 = PCA_MAX_CLASS_LOG2,
	parameter int HEADER_BYTES   = PCA_HEADER_BYTES
) (
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pca_req_t              in_type,
	input  logic [PCA_SIZE_W-1:0] in_size,
	input  logic [PCA_ADDR_W-1:0] in_addr,
	input  logic                  q_full,
	input  logic                  clear_busy,
	output logic                  push,
	output logic [pca_entry_w(MIN_CLASS_LOG2, MAX_CLASS_LOG2)-1:0] entry
);

	localparam int CLS_W      = pca_cls_w(MIN_CLASS_LOG2, MAX_CLASS_LOG2);
	localparam int SLOT_W     = pca_slot_w(MIN_CLASS_LOG2);
	localparam int SLOT_COUNT = (ARENA_BYTES >> MIN_CLASS_LOG2) + 1;
	localparam bit SLOTS_ALL  = SLOT_COUNT >= (1 << SLOT_W);
	localparam logic [SLOT_W-1:0] SLOT_LIM = SLOTS_ALL ? '0 : SLOT_W'(SLOT_COUNT);

	logic [PCA_SIZE_W:0]   total;
	logic [4:0]            blog;
	logic [PCA_ADDR_W-1:0] start;
	logic [SLOT_W-1:0]     slot;
	logic [CLS_W-1:0]      cls;
	logic                  is_free;
	logic                  reject;

	always_comb begin
		total   = {1'b0, in_size} + (PCA_SIZE_W + 1)'(HEADER_BYTES);
		blog    = pca_floor_log2(total);
		start   = in_addr - PCA_ADDR_W'(HEADER_BYTES);
		slot    = start[PCA_ADDR_W-1:MIN_CLASS_LOG2];
		is_free = (in_type == REQ_FREE);
		cls     = '0;
		reject  = 1'b0;
		if (is_free) begin
			// Null, misaligned or out-of-arena frees are dropped by the back end.
			reject = (in_addr < PCA_ADDR_W'(HEADER_BYTES))
				|| (start[MIN_CLASS_LOG2-1:0] != '0)
				|| !(SLOTS_ALL || (slot < SLOT_LIM));
		end else if (blog < 5'(MIN_CLASS_LOG2)) begin
			cls = '0;
		end else if (blog <= 5'(MAX_CLASS_LOG2)) begin
			cls = CLS_W'(blog - 5'(MIN_CLASS_LOG2) + 5'd1);
		end else begin
			reject = 1'b1;
		end
		in_ready = !q_full && !clear_busy;
		push     = in_valid && in_ready;
		entry    = {slot, cls, reject, is_free};
	end

endmodule

// ----- sv/pca_queue.sv -----
// Short FIFO between the classifier and the executor of the allocator.
// Depends on pca_pkg for its depth.
`timescale 1ns / 1ps

module pca_queue import pca_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);

	localparam int PTR_W = (PCA_QUEUE_DEPTH > 1) ? $clog2(PCA_QUEUE_DEPTH) : 1;

	logic [W-1:0]     entries_q [PCA_QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
		return (p == PTR_W'(PCA_QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (count_q == (PTR_W + 1)'(PCA_QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- sv/pca_back.sv -----
// Back end of the allocator: class heads, bump pointer, link and slot memories.
// Depends on pca_pkg; takes entries from pca_queue and drives the result register.
`timescale 1ns / 1ps

module pca_back import pca_pkg::*; #(
	parameter int ARENA_BYTES    = PCA_ARENA_BYTES,
	parameter int MIN_CLASS_LOG2 = PCA_MIN_CLASS_LOG2,
	parameter int MAX_CLASS_LOG2 = PCA_MAX_CLASS_LOG2,
	parameter int HEADER_BYTES   = PCA_HEADER_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  logic [pca_entry_w(MIN_CLASS_LOG2, MAX_CLASS_LOG2)-1:0] q_data,
	output logic                  q_pop,
	output logic                  clear_busy,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pca_status_t           out_status,
	output logic [PCA_ADDR_W-1:0] out_addr
);

	localparam int CLASS_COUNT = pca_class_count(MIN_CLASS_LOG2, MAX_CLASS_LOG2);
	localparam int CLS_W       = pca_cls_w(MIN_CLASS_LOG2, MAX_CLASS_LOG2);
	localparam int SLOT_W      = pca_slot_w(MIN_CLASS_LOG2);
	localparam int SLOT_DEPTH  = 1 << SLOT_W;
	localparam int LINK_W      = SLOT_W + 1;
	localparam int BUMP_W      = $clog2(ARENA_BYTES + 1);
	localparam int SUM_A       = (BUMP_W > MAX_CLASS_LOG2 + 2) ? BUMP_W : MAX_CLASS_LOG2 + 2;
	localparam int SUM_W       = ((SUM_A > PCA_ADDR_W + 1) ? SUM_A : PCA_ADDR_W + 1) + 1;
	localparam logic [SUM_W-1:0] ONE = SUM_W'(1);

	// Queue entry fields.
	logic              q_free;
	logic              q_reject;
	logic [CLS_W-1:0]  q_cls;
	logic [SLOT_W-1:0] q_slot;
	logic [LINK_W-1:0] head_sel;

	assign q_free   = q_data[0];
	assign q_reject = q_data[1];
	assign q_cls    = q_data[2 +: CLS_W];
	assign q_slot   = q_data[2 + CLS_W +: SLOT_W];

	pca_state_t        state_q, state_d;
	logic [SLOT_W-1:0] clr_cnt_q;
	logic [LINK_W-1:0] heads_q [CLASS_COUNT];
	logic [BUMP_W-1:0] bump_q;

	logic [LINK_W-1:0] link_mem [SLOT_DEPTH];
	logic [CLS_W:0]    slot_mem [SLOT_DEPTH];
	logic [LINK_W-1:0] link_rd_q;
	logic [CLS_W:0]    slot_rd_q;

	// Request being executed.
	logic              wk_free_q;
	logic              wk_reject_q;
	logic              wk_pop_q;
	logic [CLS_W-1:0]  wk_cls_q;
	logic [SLOT_W-1:0] wk_slot_q;

	logic              out_valid_q;
	pca_status_t       out_status_q;
	logic [PCA_ADDR_W-1:0] out_addr_q;

	// Datapath.
	logic [SUM_W-1:0]  bump_ext;
	logic [SUM_W-1:0]  wk_start;
	logic [SUM_W-1:0]  al_chunk;
	logic [SUM_W-1:0]  fr_chunk;
	logic [CLS_W-1:0]  fr_cls;
	logic              fr_used;
	logic              no_room;

	// Control.
	logic              lk_re, sm_re, lk_we, sm_we, hd_we, bp_we, out_load;
	logic [SLOT_W-1:0] lk_ra, sm_ra, sm_wa;
	logic [CLS_W:0]    sm_wd;
	logic [LINK_W-1:0] lk_wd, hd_wd;
	logic [CLS_W-1:0]  hd_idx;
	logic [BUMP_W-1:0] bp_wd;
	pca_status_t       res_status;
	logic [PCA_ADDR_W-1:0] res_addr;

	assign head_sel   = heads_q[q_cls];
	assign fr_cls     = slot_rd_q[CLS_W-1:0];
	assign fr_used    = slot_rd_q[CLS_W];
	assign bump_ext   = SUM_W'(bump_q);
	assign wk_start   = SUM_W'(wk_slot_q) << MIN_CLASS_LOG2;
	assign al_chunk   = ONE << (int'(wk_cls_q) + MIN_CLASS_LOG2);
	assign fr_chunk   = ONE << (int'(fr_cls) + MIN_CLASS_LOG2);
	assign no_room    = (bump_ext + al_chunk > SUM_W'(ARENA_BYTES))
		|| (bump_ext + SUM_W'(HEADER_BYTES) > SUM_W'(16'hFFFF));
	assign clear_busy = (state_q == BK_CLEAR);
	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_addr   = out_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		lk_re      = 1'b0;
		sm_re      = 1'b0;
		lk_ra      = SLOT_W'(head_sel - LINK_W'(1));
		sm_ra      = q_slot;
		sm_we      = 1'b0;
		sm_wa      = clr_cnt_q;
		sm_wd      = '0;
		lk_we      = 1'b0;
		lk_wd      = heads_q[fr_cls];
		hd_we      = 1'b0;
		hd_idx     = wk_cls_q;
		hd_wd      = link_rd_q;
		bp_we      = 1'b0;
		bp_wd      = bump_q;
		out_load   = 1'b0;
		res_status = STATUS_OK;
		res_addr   = '0;
		unique case (state_q)
			BK_CLEAR: begin
				sm_we = 1'b1;
				if (clr_cnt_q == '1) begin
					state_d = BK_LOAD;
				end
			end
			BK_LOAD: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = BK_EXEC;
					lk_re   = !q_free && !q_reject && (head_sel != '0);
					sm_re   = q_free && !q_reject;
				end
			end
			BK_EXEC: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = BK_LOAD;
					if (wk_free_q) begin
						if (!wk_reject_q && fr_used) begin
							sm_we = 1'b1;
							sm_wa = wk_slot_q;
							sm_wd = {1'b0, fr_cls};
							if (wk_start + fr_chunk == bump_ext) begin
								// Chunk sits on top of the bump region: give it back.
								bp_we = 1'b1;
								bp_wd = BUMP_W'(wk_start);
							end else begin
								lk_we  = 1'b1;
								hd_we  = 1'b1;
								hd_idx = fr_cls;
								hd_wd  = LINK_W'(wk_slot_q) + LINK_W'(1);
							end
						end
					end else if (wk_reject_q) begin
						res_status = STATUS_TOO_LARGE;
					end else if (wk_pop_q) begin
						hd_we    = 1'b1;
						sm_we    = 1'b1;
						sm_wa    = wk_slot_q;
						sm_wd    = {1'b1, wk_cls_q};
						res_addr = PCA_ADDR_W'(wk_start + SUM_W'(HEADER_BYTES));
					end else if (no_room) begin
						res_status = STATUS_NO_ROOM;
					end else begin
						bp_we    = 1'b1;
						bp_wd    = BUMP_W'(bump_ext + al_chunk);
						sm_we    = 1'b1;
						sm_wa    = SLOT_W'(bump_ext >> MIN_CLASS_LOG2);
						sm_wd    = {1'b1, wk_cls_q};
						res_addr = PCA_ADDR_W'(bump_ext + SUM_W'(HEADER_BYTES));
					end
				end
			end
			default: begin
				state_d = BK_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			bump_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CLASS_COUNT; i++) begin
				heads_q[i] <= '0;
			end
		end else begin
			if (state_q == BK_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (hd_we) begin
				heads_q[hd_idx] <= hd_wd;
			end
			if (bp_we) begin
				bump_q <= bp_wd;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			wk_free_q   <= q_free;
			wk_reject_q <= q_reject;
			wk_cls_q    <= q_cls;
			wk_pop_q    <= (head_sel != '0);
			wk_slot_q   <= q_free ? q_slot : lk_ra;
		end
		if (out_load) begin
			out_status_q <= res_status;
			out_addr_q   <= res_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (lk_we) begin
			link_mem[wk_slot_q] <= lk_wd;
		end
		if (lk_re) begin
			link_rd_q <= link_mem[lk_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (sm_we) begin
			slot_mem[sm_wa] <= sm_wd;
		end
		if (sm_re) begin
			slot_rd_q <= slot_mem[sm_ra];
		end
	end

endmodule

// ----- sv/pca_checker.sv -----
// Port-level checks of the allocator, attached to the top level by bind.
// Depends on pca_pkg and pow2_class_allocator_unit_defines.svh.
`timescale 1ns / 1ps
`include "pow2_class_allocator_unit_defines.svh"

module pca_checker import pca_pkg::*; #(
	parameter int HEADER_BYTES = PCA_HEADER_BYTES
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// Requests taken whose result has not yet been taken.
	logic [2:0] pending_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_xfer && !in_xfer) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`PCA_ASSERT_NOW(a_fail_zero_addr, m_axis_tvalid && (m_axis_tuser != STATUS_OK), m_axis_tdata == 16'd0, "failed request returned an address")
	`PCA_ASSERT_NOW(a_addr_past_header, m_axis_tvalid && (m_axis_tuser == STATUS_OK) && (m_axis_tdata != 16'd0), m_axis_tdata >= 16'(HEADER_BYTES), "allocated address inside header area")
	`PCA_ASSERT_NOW(a_no_invented, m_axis_tvalid, pending_q != 3'd0, "result without a pending request")
	`PCA_ASSERT_NOW(a_pending_bound, 1'b1, pending_q <= 3'(PCA_QUEUE_DEPTH + 2), "more requests pending than the block can hold")
	`PCA_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind pow2_class_allocator_unit pca_checker #(
	.HEADER_BYTES(HEADER_BYTES)
) u_pca_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

// ----- test/testbench.sv -----
// Self-checking testbench for pow2_class_allocator_unit: allocation and free requests
// in, one status/address result out per request. Depends on pca_pkg and the unit only.
`timescale 1ns / 1ps

import pca_pkg::*;

// Tracks the arena exactly as the unit should. Each accepted request is turned into
// the result it must produce. Results are then matched in arrival order.
class alloc_scoreboard;
	localparam int MIN_L2  = PCA_MIN_CLASS_LOG2;
	localparam int MAX_L2  = PCA_MAX_CLASS_LOG2;
	localparam int HEADER  = PCA_HEADER_BYTES;
	localparam int ARENA   = PCA_ARENA_BYTES;
	localparam int CLASSES = (MAX_L2 >= MIN_L2) ? (MAX_L2 - MIN_L2 + 2) : 1;
	localparam int SLOTS   = (ARENA >> MIN_L2) + 1;

	typedef struct packed {
		pca_status_t status;
		logic [15:0] data_address;
	} alloc_result_t;

	bit [16:0]     bump_offset;
	bit [16:0]     class_heads[CLASSES];
	bit [16:0]     chunk_links[SLOTS];
	bit            slot_in_use[SLOTS];
	bit [4:0]      slot_class[SLOTS];
	alloc_result_t awaited[$];
	logic [15:0]   live_addrs[$];
	int            errors;

	function new();
		bump_offset = '0;
		foreach (class_heads[i]) class_heads[i] = '0;
		foreach (slot_in_use[i]) slot_in_use[i] = 1'b0;
		errors = 0;
	endfunction

	// Works out the result of one accepted request and updates the arena copy.
	function void note_request(pca_req_t kind, bit [15:0] size, bit [15:0] addr);
		alloc_result_t res;
		int total;
		int lg;
		int cls;
		int chunk;
		int start;
		int slot;
		bit served;
		res.status = STATUS_OK;
		res.data_address = '0;
		served = 1'b0;
		if (kind == REQ_ALLOC) begin
			total = int'(size) + HEADER;
			lg = 0;
			for (int v = total; v > 1; v = v >> 1) lg++;
			if (lg < MIN_L2) cls = 0;
			else if (lg <= MAX_L2) cls = lg - MIN_L2 + 1;
			else cls = -1;
			if (cls < 0 || cls >= CLASSES) begin
				res.status = STATUS_TOO_LARGE;
			end else begin
				chunk = 1 << (cls + MIN_L2);
				if (class_heads[cls] != 0) begin
					slot = int'(class_heads[cls]) - 1;
					class_heads[cls] = chunk_links[slot];
					start = slot << MIN_L2;
					served = 1'b1;
				end else if (int'(bump_offset) + chunk > ARENA ||
						int'(bump_offset) + HEADER > 16'hFFFF) begin
					res.status = STATUS_NO_ROOM;
				end else begin
					start = int'(bump_offset);
					bump_offset = 17'(start + chunk);
					served = 1'b1;
				end
				if (served) begin
					slot_in_use[start >> MIN_L2] = 1'b1;
					slot_class[start >> MIN_L2] = 5'(cls);
					res.data_address = 16'(start + HEADER);
					live_addrs.push_back(res.data_address);
				end
			end
		end else if (int'(addr) >= HEADER) begin
			// Null, misaligned, unknown and double frees all fall through untouched.
			start = int'(addr) - HEADER;
			slot = start >> MIN_L2;
			if ((start & ((1 << MIN_L2) - 1)) == 0 && slot < SLOTS && slot_in_use[slot]) begin
				cls = int'(slot_class[slot]);
				chunk = 1 << (cls + MIN_L2);
				slot_in_use[slot] = 1'b0;
				if (start + chunk == int'(bump_offset)) begin
					bump_offset = 17'(start);
				end else begin
					chunk_links[slot] = class_heads[cls];
					class_heads[cls] = 17'(slot + 1);
				end
				foreach (live_addrs[i]) begin
					if (live_addrs[i] == addr) begin
						live_addrs.delete(i);
						break;
					end
				end
			end
		end
		awaited.push_back(res);
	endfunction

	function void check_result(pca_status_t status, logic [15:0] data_address);
		alloc_result_t want;
		if (awaited.size() == 0) begin
			$error("result with no request outstanding: status %0d, data_address %0d",
				status, data_address);
			errors++;
		end else begin
			want = awaited.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, status);
				errors++;
			end
			if (data_address !== want.data_address) begin
				$error("data_address: expected %0d, actual %0d",
					want.data_address, data_address);
				errors++;
			end
		end
	endfunction
endclass

module testbench;

	// Cycles without any transfer before the run is declared hung. The clearing sweep
	// after reset and the longest idle gaps fit well inside this.
	localparam int WATCHDOG_LIMIT = 20000;
	// Cycles allowed after the last expected result, for any stray late result.
	localparam int DRAIN_CYCLES   = 20;
	localparam int PHASE_ITEMS    = 100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [15:0] request_size, [31:16] free_address
	logic [0:0]  s_axis_tuser;   // [0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [15:0] data_address
	logic [1:0]  m_axis_tuser;   // [1:0] status

	alloc_scoreboard sb = new();

	// When set, neither side inserts idle cycles, giving back-to-back stretches.
	bit quiet_phase = 1'b0;

	pow2_class_allocator_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Idle gap length: mostly none or short, now and then a long one.
	function automatic int pick_gap(bit quiet);
		int roll;
		if (quiet) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// Offers one request and holds it until the unit takes the transfer. The valid is
	// only lowered when a gap is wanted, so back-to-back requests keep it high.
	task automatic send_request(pca_req_t kind, bit [15:0] size, bit [15:0] addr);
		int gap;
		gap = pick_gap(quiet_phase);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {addr, size};
		s_axis_tuser  <= kind;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(kind, size, addr);
	endtask

	// One random request. Frees mostly name a live chunk so that the class lists
	// really fill and drain; the rest are stray addresses, nulls and repeats.
	task automatic random_request(int alloc_pct);
		pca_req_t   kind;
		bit [15:0]  size;
		bit [15:0]  addr;
		int         roll;
		size = 16'($urandom_range(0, 65535));
		addr = 16'($urandom_range(0, 65535));
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < alloc_pct) begin
			kind = REQ_ALLOC;
			if (roll < 40) size = 16'($urandom_range(0, 255));
			else if (roll < 65) size = 16'($urandom_range(256, 2047));
			else if (roll < 85) size = 16'($urandom_range(2048, 4080));
			else if (roll < 90) size = 16'($urandom_range(4081, 8175));
		end else begin
			kind = REQ_FREE;
			if (roll < 75 && sb.live_addrs.size() > 0)
				addr = sb.live_addrs[$urandom_range(0, sb.live_addrs.size() - 1)];
			else if (roll < 88)
				addr = 16'(($urandom_range(0, 4094) << 4) + 16);
			else if (roll < 91)
				addr = '0;
		end
		send_request(kind, size, addr);
	endtask

	initial begin : stimulus
		int alloc_mix[4];
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= REQ_ALLOC;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: smallest and largest sizes, the class boundary, every kind
		// of ignored free, a push onto a class list, a pop from it, a roll-back of the
		// bump pointer, and finally the arena filling up until there is no room.
		send_request(REQ_ALLOC, 16'd0, 16'hFFFF);
		send_request(REQ_ALLOC, 16'hFFFF, 16'd0);
		send_request(REQ_ALLOC, 16'd8176, 16'd0);
		send_request(REQ_ALLOC, 16'd8175, 16'd0);
		send_request(REQ_ALLOC, 16'd15, 16'd0);
		send_request(REQ_FREE, 16'hFFFF, 16'd0);
		send_request(REQ_FREE, 16'd0, 16'd8);
		send_request(REQ_FREE, 16'd0, 16'd24);
		send_request(REQ_FREE, 16'd0, 16'hFFFF);
		send_request(REQ_FREE, 16'd0, 16'd60000);
		send_request(REQ_FREE, 16'd0, 16'd48);
		send_request(REQ_FREE, 16'd0, 16'd48);
		send_request(REQ_ALLOC, 16'd4080, 16'd0);
		send_request(REQ_FREE, 16'd0, 16'd8240);
		send_request(REQ_FREE, 16'd0, 16'd16);
		send_request(REQ_ALLOC, 16'd16, 16'd0);
		send_request(REQ_ALLOC, 16'd1, 16'd0);
		repeat (7) send_request(REQ_ALLOC, 16'd4080, 16'd0);
		send_request(REQ_ALLOC, 16'd0, 16'd0);

		// Random phases alternate between filling and draining the arena; the
		// second one runs with no idle cycles on either side.
		alloc_mix = '{85, 30, 75, 45};
		foreach (alloc_mix[p]) begin
			quiet_phase = (p == 1);
			repeat (PHASE_ITEMS) random_request(alloc_mix[p]);
		end
		quiet_phase = 1'b0;
		s_axis_tvalid <= 1'b0;

		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	// Result side: random back-pressure, each accepted transfer is checked at once.
	initial begin : result_sink
		int gap;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = pick_gap(quiet_phase);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
			sb.check_result(pca_status_t'(m_axis_tuser), m_axis_tdata);
		end
	end

	// Ends a hung run: any transfer on either side resets the count of idle cycles.
	initial begin : watchdog
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle = 0;
			else
				idle++;
			if (idle >= WATCHDOG_LIMIT) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

endmodule
